// File: rtl/core/bpd_pkg.sv
// shared types and constants for the bounded position deque
`timescale 1ns / 1ps

package bpd_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int CAP_W    = 5;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_DONE          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL          = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FRONT_BLOCKED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY         = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ITEM          = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

endpackage

// File: rtl/core/bounded_position_deque_core.sv
// bounded double-ended queue over slot positions, with a display walker
`timescale 1ns / 1ps

// Command-style deque. An item (op, value) is taken when start is high and busy
// is low. Insert and delete items give one result on the cycle after they are
// taken. A display item walks the slot memory from front to rear and gives one
// result per stored value: a read state loads the slot, then a show state
// registers the result, and busy stays high until the walk reaches the rear.
// Results are shown for exactly one cycle with strobe high and cannot be held
// off; last marks the final result of each item. A display of an empty queue
// and a delete on an empty queue give one empty status. Deletes return no data.
// Ops 5 to 7 are ignored with no result. capacity may only be written while no
// item is in progress; 0 acts as 1 and values above DEPTH act as DEPTH.
module bounded_position_deque_core #(
  parameter int DEPTH      = bpd_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bpd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bpd_pkg::OP_W-1:0]            op,
  input  logic signed [bpd_pkg::WORD_W-1:0]   value,
  input  logic                                capacity_we,
  input  logic [bpd_pkg::CAP_W-1:0]           capacity_data,
  output logic                                strobe,
  output logic [bpd_pkg::STATUS_W-1:0]        status,
  output logic signed [bpd_pkg::WORD_W-1:0]   data,
  output logic                                last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = (IW + 1 > bpd_pkg::CAP_W) ? IW + 1 : bpd_pkg::CAP_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  bpd_pkg::state_t state, state_next;

  logic [bpd_pkg::CAP_W-1:0] capacity;
  logic [IW-1:0]             front, front_next;
  logic [IW-1:0]             rear, rear_next;
  logic                      is_empty, is_empty_next;
  logic [IW-1:0]             ptr, ptr_next;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [IW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] word;

  logic                         strobe_next;
  logic [bpd_pkg::STATUS_W-1:0] status_next;
  logic [bpd_pkg::WORD_W-1:0]   data_next;
  logic                         last_next;

  logic          accept;
  logic [LW-1:0] cap_l;
  logic [LW-1:0] limit;
  logic          rear_full;
  logic          walk_end;

  assign busy     = (state != bpd_pkg::ST_IDLE);
  assign accept   = start && (state == bpd_pkg::ST_IDLE);
  assign word     = DATA_WIDTH'($unsigned(value));
  assign walk_end = (ptr == rear);

  // effective span limit, clamped to 1..DEPTH
  assign cap_l = LW'(capacity);
  always_comb begin
    if (cap_l == '0) begin
      limit = LW'(1);
    end else if (cap_l > DEPTH_L) begin
      limit = DEPTH_L;
    end else begin
      limit = cap_l;
    end
  end
  assign rear_full = (LW'(rear) + LW'(1)) >= limit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpd_pkg::ST_IDLE: begin
        if (accept && op == bpd_pkg::OP_DISPLAY && !is_empty) begin
          state_next = bpd_pkg::ST_READ;
        end
      end
      bpd_pkg::ST_READ: begin
        state_next = bpd_pkg::ST_SHOW;
      end
      bpd_pkg::ST_SHOW: begin
        state_next = walk_end ? bpd_pkg::ST_IDLE : bpd_pkg::ST_READ;
      end
      default: begin
        state_next = bpd_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    front_next    = front;
    rear_next     = rear;
    is_empty_next = is_empty;
    ptr_next      = ptr;
    mem_we        = 1'b0;
    mem_addr      = '0;
    strobe_next   = 1'b0;
    status_next   = bpd_pkg::STAT_DONE;
    data_next     = '0;
    last_next     = 1'b1;
    unique case (state)
      bpd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            bpd_pkg::OP_INS_REAR: begin
              strobe_next = 1'b1;
              if (is_empty) begin
                front_next    = '0;
                rear_next     = '0;
                is_empty_next = 1'b0;
                mem_we        = 1'b1;
              end else if (rear_full) begin
                status_next = bpd_pkg::STAT_FULL;
              end else begin
                rear_next = rear + IW'(1);
                mem_we    = 1'b1;
                mem_addr  = rear + IW'(1);
              end
            end
            bpd_pkg::OP_INS_FRONT: begin
              strobe_next = 1'b1;
              if (is_empty) begin
                front_next    = '0;
                rear_next     = '0;
                is_empty_next = 1'b0;
                mem_we        = 1'b1;
              end else if (front == '0) begin
                status_next = bpd_pkg::STAT_FRONT_BLOCKED;
              end else begin
                front_next = front - IW'(1);
                mem_we     = 1'b1;
                mem_addr   = front - IW'(1);
              end
            end
            bpd_pkg::OP_DEL_FRONT, bpd_pkg::OP_DEL_REAR: begin
              strobe_next = 1'b1;
              if (is_empty) begin
                status_next = bpd_pkg::STAT_EMPTY;
              end else if (front == rear) begin
                front_next    = '0;
                rear_next     = '0;
                is_empty_next = 1'b1;
              end else if (op == bpd_pkg::OP_DEL_FRONT) begin
                front_next = front + IW'(1);
              end else begin
                rear_next = rear - IW'(1);
              end
            end
            bpd_pkg::OP_DISPLAY: begin
              if (is_empty) begin
                strobe_next = 1'b1;
                status_next = bpd_pkg::STAT_EMPTY;
              end else begin
                ptr_next = front;
              end
            end
            default: begin
              // unused op codes give no result
            end
          endcase
        end
      end
      bpd_pkg::ST_READ: begin
        // slot at ptr is being read into rd_data
      end
      bpd_pkg::ST_SHOW: begin
        strobe_next = 1'b1;
        status_next = bpd_pkg::STAT_ITEM;
        data_next   = bpd_pkg::WORD_W'(rd_data);
        last_next   = walk_end;
        if (!walk_end) begin
          ptr_next = ptr + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpd_pkg::ST_IDLE;
      capacity <= bpd_pkg::CAP_RESET;
      front    <= '0;
      rear     <= '0;
      is_empty <= 1'b1;
      ptr      <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      rear     <= rear_next;
      is_empty <= is_empty_next;
      ptr      <= ptr_next;
      strobe   <= strobe_next;
      if (capacity_we) begin
        capacity <= capacity_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    data   <= data_next;
    last   <= last_next;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[ptr];
  end

endmodule

// File: test/bounded_position_deque_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the bounded position deque core
module bounded_position_deque_core_tb;
  import bpd_pkg::*;

  localparam int DEPTH         = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SHOWN_ERRORS  = 10;

  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  typedef enum logic {ENTRY_ITEM, ENTRY_CAP} entry_kind_t;

  typedef struct packed {
    entry_kind_t        kind;
    logic [OP_W-1:0]    op;
    logic [WORD_W-1:0]  value;
    logic [CAP_W-1:0]   cap;
  } backlog_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   data;
    logic                last;
  } deque_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [OP_W-1:0]           op = '0;
  logic signed [WORD_W-1:0]  value = '0;
  logic                      capacity_we = 1'b0;
  logic [CAP_W-1:0]          capacity_data = '0;
  logic                      busy;
  logic                      strobe;
  logic [STATUS_W-1:0]       status;
  logic signed [WORD_W-1:0]  data;
  logic                      last;

  bounded_position_deque_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH_DEFAULT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .value         (value),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data),
    .strobe        (strobe),
    .status        (status),
    .data          (data),
    .last          (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // deque image kept by the testbench
  logic [WORD_W-1:0] slot_words [DEPTH];
  int                head_pos;
  int                tail_pos;
  bit                queue_empty;
  logic [CAP_W-1:0]  cap_setting;

  deque_result_t  expected_results [$];
  backlog_entry_t op_backlog [$];

  int   cycle_count = 0;
  int   mismatch_count = 0;
  logic took_item = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   settle_left = SETTLE_CYCLES;

  task automatic push_result(input logic [STATUS_W-1:0] st, input logic [WORD_W-1:0] d,
                             input logic lst);
    deque_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    expected_results.push_back(r);
  endtask

  // applies one accepted item to the image and queues the results it causes
  task automatic deque_apply(input logic [OP_W-1:0] code, input logic [WORD_W-1:0] word);
    int lim;
    lim = (cap_setting == 0) ? 1 : (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
    case (code)
      OP_INS_REAR, OP_INS_FRONT: begin
        if (queue_empty) begin
          head_pos = 0;
          tail_pos = 0;
          queue_empty = 1'b0;
          slot_words[0] = word;
          push_result(STAT_DONE, '0, 1'b1);
        end else if (code == OP_INS_REAR && tail_pos + 1 >= lim) begin
          push_result(STAT_FULL, '0, 1'b1);
        end else if (code == OP_INS_FRONT && head_pos == 0) begin
          push_result(STAT_FRONT_BLOCKED, '0, 1'b1);
        end else if (code == OP_INS_REAR) begin
          tail_pos++;
          slot_words[tail_pos] = word;
          push_result(STAT_DONE, '0, 1'b1);
        end else begin
          head_pos--;
          slot_words[head_pos] = word;
          push_result(STAT_DONE, '0, 1'b1);
        end
      end
      OP_DEL_FRONT, OP_DEL_REAR: begin
        if (queue_empty) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          if (head_pos == tail_pos) begin
            head_pos = 0;
            tail_pos = 0;
            queue_empty = 1'b1;
          end else if (code == OP_DEL_FRONT) begin
            head_pos++;
          end else begin
            tail_pos--;
          end
          push_result(STAT_DONE, '0, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (queue_empty) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = head_pos; i <= tail_pos && i < DEPTH; i++)
            push_result(STAT_ITEM, slot_words[i], i == tail_pos);
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS)
      $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : monitor_proc
    deque_result_t want;
    if (rst) begin
      head_pos = 0;
      tail_pos = 0;
      queue_empty = 1'b1;
      cap_setting = CAP_RESET;
      took_item <= 1'b0;
    end else begin
      // compare before predicting so a new item never pairs with an older result
      if (strobe) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result: status %0d data %h last %0b",
                               status, data, last));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || data !== want.data || last !== want.last)
            flag_error($sformatf(
              "result mismatch: status exp %0d got %0d, data exp %h got %h, last exp %0b got %0b",
              want.status, status, want.data, data, want.last, last));
        end
      end
      if (capacity_we)
        cap_setting = capacity_data;
      took_item <= start && !busy;
      if (start && !busy)
        deque_apply(op, value);
    end
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_proc
    backlog_entry_t nxt;
    logic           nxt_start;
    logic           nxt_we;
    nxt_start = start && !took_item;
    nxt_we = 1'b0;
    if (!rst && !nxt_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (op_backlog.size() != 0) begin
        if (op_backlog[0].kind == ENTRY_CAP) begin
          // capacity only changes with the block idle and nothing outstanding
          if (expected_results.size() != 0 || busy || start) begin
            settle_left = SETTLE_CYCLES;
          end else if (settle_left > 0) begin
            settle_left--;
          end else begin
            nxt = op_backlog.pop_front();
            nxt_we = 1'b1;
            capacity_data <= nxt.cap;
            settle_left = SETTLE_CYCLES;
          end
        end else begin
          nxt = op_backlog.pop_front();
          nxt_start = 1'b1;
          op <= nxt.op;
          value <= nxt.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 11);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    start <= nxt_start;
    capacity_we <= nxt_we;
  end

  task automatic add_item(input logic [OP_W-1:0] code, input logic [WORD_W-1:0] word);
    backlog_entry_t e;
    e.kind  = ENTRY_ITEM;
    e.op    = code;
    e.value = word;
    e.cap   = '0;
    op_backlog.push_back(e);
  endtask

  task automatic add_cap(input logic [CAP_W-1:0] c);
    backlog_entry_t e;
    e.kind  = ENTRY_CAP;
    e.op    = '0;
    e.value = '0;
    e.cap   = c;
    op_backlog.push_back(e);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return WORD_ONES;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // grow phases lean on inserts so the queue reaches its limit
  function automatic logic [OP_W-1:0] pick_op(input bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < (grow ? 50 : 25)) return OP_INS_REAR;
    if (r < (grow ? 62 : 42)) return OP_INS_FRONT;
    if (r < (grow ? 75 : 62)) return OP_DEL_FRONT;
    if (r < (grow ? 82 : 80)) return OP_DEL_REAR;
    if (r < 96) return OP_DISPLAY;
    return OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
  endfunction

  initial begin
    bit grow;

    // directed: empty answers, both blocked inserts, extremes of the word
    add_item(OP_DISPLAY, '0);
    add_item(OP_DEL_FRONT, '0);
    add_item(OP_DEL_REAR, '0);
    add_item(OP_INS_FRONT, WORD_MAX);
    add_item(OP_INS_FRONT, 32'h1);
    add_item(OP_INS_REAR, WORD_MIN);
    add_item(OP_INS_REAR, WORD_ONES);
    add_item(OP_INS_REAR, '0);
    add_item(OP_DISPLAY, '0);
    add_item(OP_DEL_FRONT, '0);
    add_item(OP_INS_FRONT, 32'h5555_5555);
    add_item(OP_DEL_REAR, '0);
    add_item(OP_DISPLAY, '0);
    for (logic [OP_W:0] u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++)
      add_item(u[OP_W-1:0], $urandom);
    // deleting down to the only element empties the queue
    add_item(OP_DEL_FRONT, '0);
    add_item(OP_DEL_FRONT, '0);
    add_item(OP_DEL_FRONT, '0);
    add_item(OP_DISPLAY, '0);
    // single slot
    add_cap(5'd1);
    add_item(OP_INS_REAR, 32'hAAAA_AAAA);
    add_item(OP_INS_REAR, 32'h1234_5678);
    add_item(OP_INS_FRONT, 32'h1);
    add_item(OP_DISPLAY, '0);
    add_item(OP_DEL_REAR, '0);
    // zero capacity acts as one slot
    add_cap(5'd0);
    add_item(OP_INS_REAR, $urandom);
    add_item(OP_INS_REAR, $urandom);
    add_item(OP_DEL_FRONT, '0);

    // oversized capacity acts as full depth: fill past the end, show all slots
    add_cap(5'd31);
    for (int i = 0; i <= DEPTH; i++)
      add_item(OP_INS_REAR, pick_word());
    add_item(OP_DISPLAY, '0);
    // capacity lowered below the occupied span
    add_cap(CAP_W'($urandom_range(1, 8)));
    for (int i = 0; i < 10; i++)
      add_item(pick_op(1'b0), pick_word());

    for (int p = 0; p < 3; p++) begin
      if ($urandom_range(0, 2) == 0)
        add_cap(CAP_W'($urandom_range(0, 31)));
      else
        add_cap(CAP_W'($urandom_range(1, 6)));
      grow = $urandom_range(0, 1);
      for (int i = 0; i < 14; i++)
        add_item(pick_op(grow), pick_word());
    end
    add_cap(CAP_RESET);
    for (int i = 0; i < 12; i++)
      add_item(pick_op(1'b1), pick_word());
    add_item(OP_DISPLAY, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bpd_pkg.sv
rtl/core/bounded_position_deque_core.sv
test/bounded_position_deque_core_tb.sv
